/* design/hsv_pkg.sv */
// shared types, constants and widths for the hsv to rgb converter
`timescale 1ns / 1ps

package hsv_pkg;

  // input and output field widths
  localparam int HUE_W = 9;
  localparam int SAT_W = 7;
  localparam int VAL_W = 8;
  localparam int CHAN_W = 8;

  // hue and saturation limits
  localparam int HUE_WRAP = 360;
  localparam int SAT_MAX = 100;
  localparam int SECTOR_DEG = 60;
  localparam int HM_W = 7;
  localparam int DIST_W = 6;

  // every channel is a fraction over DEN, rounded half up
  localparam int DEN = 6000;
  localparam int HALF = DEN / 2;
  localparam int FRAC_W = 13;
  localparam int NUM_W = 21;

  // x / 6000 = (x >> 4) / 375, the latter by reciprocal multiply
  localparam int PRE_SHIFT = 4;
  localparam int DIV_BY = DEN / (1 << PRE_SHIFT);
  localparam int DIV_K = 25;
  localparam int DIV_MUL = ((1 << DIV_K) + DIV_BY - 1) / DIV_BY;
  localparam int Y_W = NUM_W - PRE_SHIFT;
  localparam int MUL_W = 17;
  localparam int PROD_W = Y_W + MUL_W;

  // default queue depths
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 4;

  // 60 degree sectors, named by the hues at their ends
  typedef enum logic [2:0] {
    SEC_RED_YELLOW,
    SEC_YELLOW_GREEN,
    SEC_GREEN_CYAN,
    SEC_CYAN_BLUE,
    SEC_BLUE_MAGENTA,
    SEC_MAGENTA_RED
  } sector_t;

  // classified word handed from front to back
  typedef struct packed {
    sector_t             sector;
    logic [VAL_W-1:0]    v;
    logic [FRAC_W-1:0]   m_mid;
    logic [FRAC_W-1:0]   m_bot;
  } hsv_work_t;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } hsv_rgb_t;

endpackage

/* design/hsv_to_rgb.sv */
// top level of the hsv to rgb pixel converter
//
//   channel  ports                            handshake
//   pixel    hue, saturation, brightness      push / full
//   colour   red, green, blue                 pop / empty
//
// one word per cycle sustained while colour words are popped and neither queue fills; a pushed
// word passes the front register, work queue, two multiply stages and output queue before
// empty falls and it can be popped
// full rises when the work queue and front register hold four words
// the back end issues only while the output queue has room for words in flight
// rst clears all valid flags and queue pointers; data registers are not reset
`timescale 1ns / 1ps

module hsv_to_rgb #(
  parameter int QUEUE_DEPTH = hsv_pkg::QUEUE_DEPTH_DEF,
  parameter int OUT_DEPTH   = hsv_pkg::OUT_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [hsv_pkg::HUE_W-1:0]  hue,
  input  logic [hsv_pkg::SAT_W-1:0]  saturation,
  input  logic [hsv_pkg::VAL_W-1:0]  brightness,
  output logic                       empty,
  input  logic                       pop,
  output logic [hsv_pkg::CHAN_W-1:0] red,
  output logic [hsv_pkg::CHAN_W-1:0] green,
  output logic [hsv_pkg::CHAN_W-1:0] blue
);

  import hsv_pkg::*;

  localparam int WORK_W = $bits(hsv_work_t);
  localparam int RGB_W  = $bits(hsv_rgb_t);

  logic                             front_valid;
  hsv_work_t                        front_work;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count;
  logic [WORK_W-1:0]                queue_rdata;
  hsv_work_t                        queue_work;
  logic                             queue_take;
  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count;
  logic                             res_valid;
  hsv_rgb_t                         res;
  logic [RGB_W-1:0]                 out_rdata;
  hsv_rgb_t                         out_word;
  logic                             out_pop;

  hsv_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .queue_count(queue_count),
    .work_valid (front_valid),
    .work       (front_work)
  );

  hsv_fifo #(
    .WIDTH(WORK_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_work_queue (
    .clk  (clk),
    .rst  (rst),
    .push (front_valid),
    .wdata(front_work),
    .pop  (queue_take),
    .rdata(queue_rdata),
    .count(queue_count)
  );

  assign queue_work = hsv_work_t'(queue_rdata);

  hsv_back #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .work_valid(queue_count != '0),
    .work      (queue_work),
    .work_take (queue_take),
    .out_count (out_count),
    .res_valid (res_valid),
    .res       (res)
  );

  hsv_fifo #(
    .WIDTH(RGB_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk  (clk),
    .rst  (rst),
    .push (res_valid),
    .wdata(res),
    .pop  (out_pop),
    .rdata(out_rdata),
    .count(out_count)
  );

  assign empty    = (out_count == '0);
  assign out_pop  = pop && !empty;
  assign out_word = hsv_rgb_t'(out_rdata);
  assign red      = out_word.r;
  assign green    = out_word.g;
  assign blue     = out_word.b;

endmodule

/* design/hsv_fifo.sv */
// small register queue with count, used between the stages and at the output
`timescale 1ns / 1ps

module hsv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [PW-1:0]    wptr_next;
  logic [PW-1:0]    rptr_next;
  logic [CW-1:0]    count_next;

  always_comb begin
    wptr_next = wptr;
    rptr_next = rptr;
    if (push) begin
      wptr_next = (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
    end
    if (pop) begin
      rptr_next = (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
    end
    count_next = count + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr_next;
      rptr  <= rptr_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  assign rdata = mem[rptr];

endmodule

/* design/hsv_front.sv */
// front end: takes a pixel, folds hue and saturation, finds the sector and weights
`timescale 1ns / 1ps

module hsv_front #(
  parameter int QUEUE_DEPTH = hsv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [hsv_pkg::HUE_W-1:0]        hue,
  input  logic [hsv_pkg::SAT_W-1:0]        saturation,
  input  logic [hsv_pkg::VAL_W-1:0]        brightness,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count,
  output logic                             work_valid,
  output hsv_pkg::hsv_work_t               work
);

  import hsv_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1) + 1;

  logic              accept;
  logic [HUE_W-1:0]  h;
  logic [HUE_W-1:0]  hm_wide;
  logic [HM_W-1:0]   hm;
  logic [DIST_W-1:0] d;
  logic [SAT_W-1:0]  s;
  logic [FRAC_W-1:0] sd;
  logic [FRAC_W-1:0] s60;
  sector_t           sector;
  hsv_work_t         work_next;

  // words in the queue plus the one held here must leave room for one more
  assign full   = ((CW'(queue_count) + CW'(work_valid)) >= CW'(QUEUE_DEPTH));
  assign accept = push && !full;

  always_comb begin
    h = (hue >= HUE_W'(HUE_WRAP)) ? hue - HUE_W'(HUE_WRAP) : hue;
    s = (saturation > SAT_W'(SAT_MAX)) ? SAT_W'(SAT_MAX) : saturation;

    if (h < HUE_W'(SECTOR_DEG)) begin
      sector = SEC_RED_YELLOW;
    end else if (h < HUE_W'(2 * SECTOR_DEG)) begin
      sector = SEC_YELLOW_GREEN;
    end else if (h < HUE_W'(3 * SECTOR_DEG)) begin
      sector = SEC_GREEN_CYAN;
    end else if (h < HUE_W'(4 * SECTOR_DEG)) begin
      sector = SEC_CYAN_BLUE;
    end else if (h < HUE_W'(5 * SECTOR_DEG)) begin
      sector = SEC_BLUE_MAGENTA;
    end else begin
      sector = SEC_MAGENTA_RED;
    end

    // hue within its 120 degree period, then distance from its middle
    if (h >= HUE_W'(4 * SECTOR_DEG)) begin
      hm_wide = h - HUE_W'(4 * SECTOR_DEG);
    end else if (h >= HUE_W'(2 * SECTOR_DEG)) begin
      hm_wide = h - HUE_W'(2 * SECTOR_DEG);
    end else begin
      hm_wide = h;
    end
    hm = hm_wide[HM_W-1:0];
    d  = (hm >= HM_W'(SECTOR_DEG)) ? DIST_W'(hm - HM_W'(SECTOR_DEG))
                                   : DIST_W'(HM_W'(SECTOR_DEG) - hm);

    // channel = v * (6000 - s*d) / 6000; bottom channel has d = 60
    sd  = FRAC_W'(s) * FRAC_W'(d);
    s60 = FRAC_W'(s) * FRAC_W'(SECTOR_DEG);

    work_next.sector = sector;
    work_next.v      = brightness;
    work_next.m_mid  = FRAC_W'(DEN) - sd;
    work_next.m_bot  = FRAC_W'(DEN) - s60;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else begin
      work_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work <= work_next;
    end
  end

endmodule

/* design/hsv_back.sv */
// back end: weight products, divide by 6000 with rounding, channel steering
`timescale 1ns / 1ps

module hsv_back #(
  parameter int OUT_DEPTH = hsv_pkg::OUT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           work_valid,
  input  hsv_pkg::hsv_work_t             work,
  output logic                           work_take,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           res_valid,
  output hsv_pkg::hsv_rgb_t              res
);

  import hsv_pkg::*;

  localparam int CW = $clog2(OUT_DEPTH + 1) + 2;

  logic              a_valid;
  sector_t           a_sector;
  logic [VAL_W-1:0]  a_v;
  logic [NUM_W-1:0]  a_nmid;
  logic [NUM_W-1:0]  a_nbot;

  logic              b_valid;
  sector_t           b_sector;
  logic [VAL_W-1:0]  b_v;
  logic [PROD_W-1:0] b_pmid;
  logic [PROD_W-1:0] b_pbot;

  logic [NUM_W-1:0]  rmid;
  logic [NUM_W-1:0]  rbot;
  logic [Y_W-1:0]    ymid;
  logic [Y_W-1:0]    ybot;
  logic [CW-1:0]     pending;
  logic [CHAN_W-1:0] t;
  logic [CHAN_W-1:0] m;
  logic [CHAN_W-1:0] bt;

  // words in flight plus queued results may not exceed the output queue
  assign pending   = CW'(out_count) + CW'(a_valid) + CW'(b_valid);
  assign work_take = work_valid && (pending < CW'(OUT_DEPTH));

  always_comb begin
    rmid = a_nmid + NUM_W'(HALF);
    rbot = a_nbot + NUM_W'(HALF);
    ymid = rmid[NUM_W-1:PRE_SHIFT];
    ybot = rbot[NUM_W-1:PRE_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= work_take;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (work_take) begin
      a_sector <= work.sector;
      a_v      <= work.v;
      a_nmid   <= NUM_W'(work.v) * NUM_W'(work.m_mid);
      a_nbot   <= NUM_W'(work.v) * NUM_W'(work.m_bot);
    end
    if (a_valid) begin
      b_sector <= a_sector;
      b_v      <= a_v;
      b_pmid   <= PROD_W'(ymid) * PROD_W'(DIV_MUL);
      b_pbot   <= PROD_W'(ybot) * PROD_W'(DIV_MUL);
    end
  end

  always_comb begin
    t  = b_v;
    m  = b_pmid[DIV_K +: CHAN_W];
    bt = b_pbot[DIV_K +: CHAN_W];
    unique case (b_sector)
      SEC_RED_YELLOW: begin
        res.r = t;  res.g = m;  res.b = bt;
      end
      SEC_YELLOW_GREEN: begin
        res.r = m;  res.g = t;  res.b = bt;
      end
      SEC_GREEN_CYAN: begin
        res.r = bt; res.g = t;  res.b = m;
      end
      SEC_CYAN_BLUE: begin
        res.r = bt; res.g = m;  res.b = t;
      end
      SEC_BLUE_MAGENTA: begin
        res.r = m;  res.g = bt; res.b = t;
      end
      default: begin
        res.r = t;  res.g = bt; res.b = m;
      end
    endcase
  end

  assign res_valid = b_valid;

endmodule

/* bench/hsv_checker.sv */
// checker for the hsv to rgb converter: watches both channels, predicts and compares
`timescale 1ns / 1ps

module hsv_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic                       full,
  input  logic [hsv_pkg::HUE_W-1:0]  hue,
  input  logic [hsv_pkg::SAT_W-1:0]  saturation,
  input  logic [hsv_pkg::VAL_W-1:0]  brightness,
  input  logic                       empty,
  input  logic                       pop,
  input  logic [hsv_pkg::CHAN_W-1:0] red,
  input  logic [hsv_pkg::CHAN_W-1:0] green,
  input  logic [hsv_pkg::CHAN_W-1:0] blue,
  output int                         fail_count,
  output int                         pending
);
  import hsv_pkg::*;

  hsv_rgb_t colour_q[$];

  // exact fraction over DEN per channel, rounded half up
  function automatic hsv_rgb_t convert_pixel(logic [HUE_W-1:0] h_in,
                                             logic [SAT_W-1:0] s_in,
                                             logic [VAL_W-1:0] v_in);
    int h;
    int s;
    int v;
    int hm;
    int hue_dist;
    int top_n;
    int mid_n;
    int bot_n;
    logic [CHAN_W-1:0] t;
    logic [CHAN_W-1:0] m;
    logic [CHAN_W-1:0] b;
    sector_t sec;
    hsv_rgb_t px;
    h = int'(h_in);
    s = int'(s_in);
    v = int'(v_in);
    if (h >= HUE_WRAP) h = h - HUE_WRAP;
    if (s > SAT_MAX) s = SAT_MAX;
    hm = h % (2 * SECTOR_DEG);
    hue_dist = (hm >= SECTOR_DEG) ? hm - SECTOR_DEG : SECTOR_DEG - hm;
    top_n = v * DEN;
    bot_n = v * (SAT_MAX - s) * SECTOR_DEG;
    mid_n = bot_n + v * s * (SECTOR_DEG - hue_dist);
    t = CHAN_W'((top_n + HALF) / DEN);
    m = CHAN_W'((mid_n + HALF) / DEN);
    b = CHAN_W'((bot_n + HALF) / DEN);
    sec = sector_t'(h / SECTOR_DEG);
    case (sec)
      SEC_RED_YELLOW:   px = '{r: t, g: m, b: b};
      SEC_YELLOW_GREEN: px = '{r: m, g: t, b: b};
      SEC_GREEN_CYAN:   px = '{r: b, g: t, b: m};
      SEC_CYAN_BLUE:    px = '{r: b, g: m, b: t};
      SEC_BLUE_MAGENTA: px = '{r: m, g: b, b: t};
      default:          px = '{r: t, g: b, b: m};
    endcase
    return px;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    hsv_rgb_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (colour_q.size() == 0) begin
          report_mismatch($sformatf("colour word %0d/%0d/%0d with nothing expected",
                                    red, green, blue));
        end else begin
          want = colour_q.pop_front();
          if (red !== want.r)
            report_mismatch($sformatf("red got %0d want %0d", red, want.r));
          if (green !== want.g)
            report_mismatch($sformatf("green got %0d want %0d", green, want.g));
          if (blue !== want.b)
            report_mismatch($sformatf("blue got %0d want %0d", blue, want.b));
        end
      end
      if (push && !full)
        colour_q.push_back(convert_pixel(hue, saturation, brightness));
    end
    pending = colour_q.size();
  end

endmodule

/* bench/testbench.sv */
// top of the hsv to rgb bench: clock, reset, pixel stimulus, colour drain and verdict
`timescale 1ns / 1ps

module testbench;
  import hsv_pkg::*;

  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  logic [HUE_W-1:0]    hue;
  logic [SAT_W-1:0]    saturation;
  logic [VAL_W-1:0]    brightness;
  logic                empty;
  logic                pop;
  logic [CHAN_W-1:0]   red;
  logic [CHAN_W-1:0]   green;
  logic [CHAN_W-1:0]   blue;
  int                  fail_count;
  int                  pending;

  bit                  free_run;
  bit                  hold_req;

  hsv_to_rgb dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .hue(hue), .saturation(saturation), .brightness(brightness),
    .empty(empty), .pop(pop),
    .red(red), .green(green), .blue(blue)
  );

  hsv_checker u_checker (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .hue(hue), .saturation(saturation), .brightness(brightness),
    .empty(empty), .pop(pop),
    .red(red), .green(green), .blue(blue),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("** hsv_to_rgb: FAILED **");
    $finish;
  end

  // mostly short gaps, the odd long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (free_run) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // entered and left at a falling edge
  task automatic send_pixel(logic [HUE_W-1:0] h, logic [SAT_W-1:0] s,
                            logic [VAL_W-1:0] v);
    int gap;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    push       <= 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_random();
    logic [HUE_W-1:0] h;
    logic [SAT_W-1:0] s;
    logic [VAL_W-1:0] v;
    h = HUE_W'($urandom_range(0, HUE_WRAP - 1));
    s = SAT_W'($urandom_range(0, SAT_MAX));
    v = VAL_W'($urandom_range(0, 255));
    // out-of-range hue and saturation now and then
    if ($urandom_range(0, 9) == 0) h = HUE_W'($urandom_range(HUE_WRAP, 511));
    if ($urandom_range(0, 9) == 0) s = SAT_W'($urandom_range(SAT_MAX + 1, 127));
    send_pixel(h, s, v);
  endtask

  // colour side: random stalls, one long hold-off on request
  initial begin
    int stall_left;
    pop = 1'b0;
    stall_left = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if (!free_run && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
      @(negedge clk);
    end
  end

  initial begin
    rst        = 1'b1;
    push       = 1'b0;
    hue        = '0;
    saturation = '0;
    brightness = '0;
    free_run   = 1'b0;
    hold_req   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: field extremes, every sector with its lower edge, wrap, clamp, grey
    send_pixel(9'd0,   7'd0,   8'd0);
    send_pixel(9'd359, 7'd100, 8'd255);
    send_pixel(9'd0,   7'd100, 8'd255);
    send_pixel(9'd59,  7'd100, 8'd255);
    send_pixel(9'd60,  7'd100, 8'd255);
    send_pixel(9'd119, 7'd80,  8'd200);
    send_pixel(9'd120, 7'd100, 8'd255);
    send_pixel(9'd150, 7'd37,  8'd101);
    send_pixel(9'd180, 7'd100, 8'd255);
    send_pixel(9'd239, 7'd55,  8'd17);
    send_pixel(9'd240, 7'd100, 8'd255);
    send_pixel(9'd270, 7'd50,  8'd255);
    send_pixel(9'd300, 7'd100, 8'd255);
    send_pixel(9'd330, 7'd1,   8'd1);
    send_pixel(9'd360, 7'd100, 8'd255);
    send_pixel(9'd511, 7'd127, 8'd255);
    send_pixel(9'd400, 7'd101, 8'd128);
    send_pixel(9'd30,  7'd127, 8'd77);
    send_pixel(9'd200, 7'd0,   8'd200);
    send_pixel(9'd30,  7'd50,  8'd255);
    send_pixel(9'd90,  7'd50,  8'd3);
    send_pixel(9'd256, 7'd64,  8'd128);
    send_pixel(9'd45,  7'd99,  8'd254);

    repeat (400) send_random();

    // long hold-off on the colour side while pixels keep coming
    free_run = 1'b1;
    hold_req = 1'b1;
    repeat (60) send_random();
    free_run = 1'b0;

    // sender waits for the converter to drain completely
    push <= 1'b0;
    wait (pending == 0);
    @(negedge clk);

    // back to back on both sides
    free_run = 1'b1;
    repeat (350) send_random();
    free_run = 1'b0;

    repeat (420) send_random();

    push <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** hsv_to_rgb: PASSED **");
    end else begin
      $display("** hsv_to_rgb: FAILED **");
    end
    $finish;
  end

endmodule
